// ===== rtl/mwid_pkg.sv =====
// ----------------------------------------------------------------------------
// mwid_pkg
// Types and codes shared by the mixed-width instruction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mwid_pkg;

    // Input transfer: one fetched word and the low address bits
    typedef struct packed {
        logic [1:0]  address_low;
        logic [31:0] fetch_word;
    } fetch_t;

    // Output transfer: one micro-op
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  op_kind;
        logic [3:0]  alu_func;
        logic [5:0]  dest_reg;
        logic [5:0]  src_a_reg;
        logic [5:0]  src_b_reg;
        logic [31:0] immediate;
        logic        set_flags;
        logic [5:0]  condition;
        logic [2:0]  instr_length;
        logic        last_op;
    } uop_t;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD32    = 2'd1;
    localparam logic [1:0] ST_PARALLEL = 2'd2;
    localparam logic [1:0] ST_BAD16    = 2'd3;

    // Micro-op kinds
    localparam logic [2:0] K_NOP = 3'd0;
    localparam logic [2:0] K_ALU = 3'd1;
    localparam logic [2:0] K_MOV = 3'd2;
    localparam logic [2:0] K_LD  = 3'd3;
    localparam logic [2:0] K_ST  = 3'd4;

    // ALU functions
    localparam logic [3:0] F_ADD  = 4'd0;
    localparam logic [3:0] F_ADDC = 4'd1;
    localparam logic [3:0] F_SUB  = 4'd2;
    localparam logic [3:0] F_SUBC = 4'd3;
    localparam logic [3:0] F_AND  = 4'd4;
    localparam logic [3:0] F_OR   = 4'd5;
    localparam logic [3:0] F_XOR  = 4'd6;
    localparam logic [3:0] F_SLL  = 4'd7;
    localparam logic [3:0] F_SRL  = 4'd8;
    localparam logic [3:0] F_SRA  = 4'd9;
    localparam logic [3:0] F_ROR  = 4'd10;
    localparam logic [3:0] F_ROL  = 4'd11;

    localparam logic [5:0] NOREG  = 6'd32;
    localparam logic [5:0] UNCOND = 6'd32;

    localparam logic [2:0] LEN16 = 3'd2;
    localparam logic [2:0] LEN32 = 3'd4;

    // 32-bit major opcodes and sub-function field
    localparam logic [4:0] OP32_SPECIAL = 5'd0;
    localparam logic [4:0] OP32_IMM     = 5'd1;
    localparam logic [4:0] OP32_IMMHI   = 5'd5;
    localparam logic [2:0] F3_LDI       = 3'd6;

    localparam logic [5:0] FN_NOP   = 6'h00;
    localparam logic [5:0] FN_ADD   = 6'h08;
    localparam logic [5:0] FN_ADDC  = 6'h09;
    localparam logic [5:0] FN_SUB   = 6'h0A;
    localparam logic [5:0] FN_SUBC  = 6'h0B;
    localparam logic [5:0] FN_CMP   = 6'h0C;
    localparam logic [5:0] FN_CMPZ  = 6'h0D;
    localparam logic [5:0] FN_NEG   = 6'h0F;
    localparam logic [5:0] FN_AND   = 6'h10;
    localparam logic [5:0] FN_OR    = 6'h11;
    localparam logic [5:0] FN_NOT   = 6'h12;
    localparam logic [5:0] FN_XOR   = 6'h13;
    localparam logic [5:0] FN_BITCLR = 6'h14;
    localparam logic [5:0] FN_BITSET = 6'h15;
    localparam logic [5:0] FN_BITTST = 6'h16;
    localparam logic [5:0] FN_BITTGL = 6'h17;
    localparam logic [5:0] FN_SLL   = 6'h18;
    localparam logic [5:0] FN_SRL   = 6'h1A;
    localparam logic [5:0] FN_SRA   = 6'h1B;
    localparam logic [5:0] FN_ROR   = 6'h1C;
    localparam logic [5:0] FN_ROL   = 6'h1E;
    localparam logic [5:0] FN_MV    = 6'h2B;

    // 16-bit major opcodes and sub-functions
    localparam logic [2:0] OP16_MISC  = 3'd0;
    localparam logic [2:0] OP16_STACK = 3'd2;
    localparam logic [2:0] OP16_SWFP  = 3'd7;
    localparam logic [3:0] F4_MV      = 4'h3;
    localparam logic [3:0] F4_POP     = 4'hA;
    localparam logic [3:0] F4_PUSH    = 4'hE;
    localparam logic [2:0] F3_SWFP    = 3'd4;

    localparam logic [5:0]  FP_REG = 6'd2;
    localparam logic [31:0] STACK_STEP = 32'd4;

endpackage

`default_nettype wire

// ===== rtl/mixed_width_instruction_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// mixed_width_instruction_decoder_unit
// Decodes one 16/32-bit instruction word per transfer into micro-ops.
// ----------------------------------------------------------------------------
// Usage:
//   fetch channel  : fetch_valid/fetch_ready/fetch carry one aligned 32-bit
//                    word plus the low two address bits per transfer.
//   uop channel    : uop_valid/uop_ready/uop carry one micro-op per transfer;
//                    last_op marks the final micro-op of an instruction.
//   Output         : a micro-op is on uop in the cycle after its fetch transfer.
//   Throughput     : one fetch transfer per cycle while uop_ready is high, for
//                    instructions that give one micro-op; pop!/push! give two
//                    micro-ops and hold off the next fetch transfer while the
//                    second micro-op waits in the pending register.
//   Decode is one pass of combinational logic into the output register.
//   Reset          : rst_n clears both valid flags; nothing is in flight.
//   Stall          : while uop_ready is low, the result register holds its
//                    micro-op and fetch_ready falls once it is occupied, so no
//                    word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_width_instruction_decoder_unit (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   fetch_valid,
    output logic                  fetch_ready,
    input  wire mwid_pkg::fetch_t fetch,
    output logic                  uop_valid,
    input  wire                   uop_ready,
    output mwid_pkg::uop_t        uop
);

    // Builds an ok micro-op; length and last flag are filled in later
    function automatic mwid_pkg::uop_t mk(
        input logic [2:0]  kind,
        input logic [3:0]  func,
        input logic [5:0]  dst,
        input logic [5:0]  sa,
        input logic [5:0]  sb,
        input logic [31:0] imm,
        input logic        flags,
        input logic [5:0]  cond
    );
        mwid_pkg::uop_t u;
        u.status       = mwid_pkg::ST_OK;
        u.op_kind      = kind;
        u.alu_func     = func;
        u.dest_reg     = dst;
        u.src_a_reg    = sa;
        u.src_b_reg    = sb;
        u.immediate    = imm;
        u.set_flags    = flags;
        u.condition    = cond;
        u.instr_length = mwid_pkg::LEN16;
        u.last_op      = 1'b1;
        return u;
    endfunction

    // Output register and the pending second micro-op
    mwid_pkg::uop_t out_reg,  out_next;
    logic           out_valid_reg, out_valid_next;
    mwid_pkg::uop_t pend_reg, pend_next;
    logic           pend_valid_reg, pend_valid_next;

    logic           accept;
    logic           advance;

    // Decode results
    mwid_pkg::uop_t dec0, dec1;
    logic           dec_two;

    // Output register can take a new micro-op when empty or being drained
    assign advance     = !out_valid_reg || uop_ready;
    assign fetch_ready = advance && !pend_valid_reg;
    assign accept      = fetch_valid && fetch_ready;

    assign uop_valid = out_valid_reg;
    assign uop       = out_reg;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [31:0] w;
        logic        is32;
        logic        is_par;
        logic [29:0] c32;
        logic [14:0] c16;
        logic [4:0]  op;
        logic [5:0]  rd, ra, rb;
        logic        cu;
        logic [15:0] imm16;
        logic [2:0]  f3;
        logic [2:0]  op16;
        logic [5:0]  r8, rdh, rag;
        logic [3:0]  f4;
        logic        ok;
        logic [2:0]  len;
        logic [1:0]  err_st;
        mwid_pkg::uop_t err;

        w      = fetch.fetch_word;
        is32   = (fetch.address_low == 2'd0) && w[31] && w[15];
        is_par = (fetch.address_low == 2'd0) && w[15] && !w[31];
        // parity bits squeezed out
        c32    = {w[30:16], w[14:0]};
        c16    = (fetch.address_low == 2'd2) ? w[30:16] : w[14:0];

        op    = c32[29:25];
        rd    = {1'b0, c32[24:20]};
        ra    = {1'b0, c32[19:15]};
        rb    = {1'b0, c32[14:10]};
        cu    = c32[0];
        imm16 = c32[16:1];
        f3    = c32[19:17];

        op16  = c16[14:12];
        r8    = {2'b00, c16[11:8]};
        rdh   = {1'b0, c16[7], c16[11:8]};
        rag   = {3'b000, c16[6:4]};
        f4    = c16[3:0];

        err = mk(mwid_pkg::K_NOP, mwid_pkg::F_ADD, mwid_pkg::NOREG, mwid_pkg::NOREG,
                 mwid_pkg::NOREG, 32'd0, 1'b0, mwid_pkg::UNCOND);
        dec0    = err;
        dec1    = err;
        dec_two = 1'b0;
        ok      = 1'b1;
        len     = mwid_pkg::LEN16;
        err_st  = mwid_pkg::ST_BAD16;

        if (is32)
        begin
            len    = mwid_pkg::LEN32;
            err_st = mwid_pkg::ST_BAD32;
            if (op == mwid_pkg::OP32_SPECIAL)
            begin
                case (c32[6:1])
                    mwid_pkg::FN_NOP:  dec0 = err;
                    mwid_pkg::FN_ADD:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_ADD, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_ADDC: dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_ADDC, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_SUB:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_SUB, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_SUBC: dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_SUBC, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_CMP:
                    begin
                        // compare needs the tcs bits of rD both set
                        ok   = (rd[1:0] == 2'b11);
                        dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_SUB, mwid_pkg::NOREG, ra, rb,
                                  32'd0, 1'b1, mwid_pkg::UNCOND);
                    end
                    mwid_pkg::FN_CMPZ:
                    begin
                        ok   = (rd[1:0] == 2'b11);
                        dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_SUB, mwid_pkg::NOREG, ra,
                                  mwid_pkg::NOREG, 32'd0, 1'b1, mwid_pkg::UNCOND);
                    end
                    mwid_pkg::FN_NEG:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_SUB, rd,
                                                 mwid_pkg::NOREG, rb, 32'd0, cu,
                                                 mwid_pkg::UNCOND);
                    mwid_pkg::FN_AND:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_AND, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_OR:   dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_OR, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_NOT:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_XOR, rd, ra,
                                                 mwid_pkg::NOREG, 32'hFFFF_FFFF, cu,
                                                 mwid_pkg::UNCOND);
                    mwid_pkg::FN_XOR:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_XOR, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_BITCLR: dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_AND, rd, ra,
                                                   mwid_pkg::NOREG, ~(32'd1 << rb[4:0]), cu,
                                                   mwid_pkg::UNCOND);
                    mwid_pkg::FN_BITSET: dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_OR, rd, ra,
                                                   mwid_pkg::NOREG, 32'd1 << rb[4:0], cu,
                                                   mwid_pkg::UNCOND);
                    mwid_pkg::FN_BITTST: dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_AND,
                                                   mwid_pkg::NOREG, ra, mwid_pkg::NOREG,
                                                   32'd1 << rb[4:0], cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_BITTGL: dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_XOR,
                                                   mwid_pkg::NOREG, ra, mwid_pkg::NOREG,
                                                   32'd1 << rb[4:0], cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_SLL:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_SLL, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_SRL:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_SRL, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_SRA:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_SRA, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_ROR:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_ROR, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    mwid_pkg::FN_ROL:  dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_ROL, rd, ra, rb,
                                                 32'd0, cu, mwid_pkg::UNCOND);
                    // conditional move: rB field is the condition code
                    mwid_pkg::FN_MV:   dec0 = mk(mwid_pkg::K_MOV, mwid_pkg::F_ADD, rd, ra,
                                                 mwid_pkg::NOREG, 32'd0, 1'b0, rb);
                    default:           ok = 1'b0;
                endcase
            end
            else if (op == mwid_pkg::OP32_IMM && f3 == mwid_pkg::F3_LDI)
            begin
                dec0 = mk(mwid_pkg::K_MOV, mwid_pkg::F_ADD, rd, mwid_pkg::NOREG,
                          mwid_pkg::NOREG, {{16{imm16[15]}}, imm16}, 1'b0, mwid_pkg::UNCOND);
            end
            else if (op == mwid_pkg::OP32_IMMHI && f3 == mwid_pkg::F3_LDI)
            begin
                dec0 = mk(mwid_pkg::K_MOV, mwid_pkg::F_ADD, rd, mwid_pkg::NOREG,
                          mwid_pkg::NOREG, {imm16, 16'd0}, 1'b0, mwid_pkg::UNCOND);
            end
            else
            begin
                ok = 1'b0;
            end
        end
        else if (!is_par)
        begin
            case (op16)
                mwid_pkg::OP16_MISC:
                begin
                    ok   = (f4 == mwid_pkg::F4_MV);
                    dec0 = mk(mwid_pkg::K_MOV, mwid_pkg::F_ADD, r8, {2'b00, c16[7:4]},
                              mwid_pkg::NOREG, 32'd0, 1'b0, mwid_pkg::UNCOND);
                end
                mwid_pkg::OP16_STACK:
                begin
                    if (f4 == mwid_pkg::F4_POP)
                    begin
                        dec0 = mk(mwid_pkg::K_LD, mwid_pkg::F_ADD, rdh, rag, mwid_pkg::NOREG,
                                  32'd0, 1'b0, mwid_pkg::UNCOND);
                        dec1 = mk(mwid_pkg::K_ALU, mwid_pkg::F_ADD, rag, rag, mwid_pkg::NOREG,
                                  mwid_pkg::STACK_STEP, 1'b0, mwid_pkg::UNCOND);
                        dec_two = 1'b1;
                    end
                    else if (f4 == mwid_pkg::F4_PUSH)
                    begin
                        dec0 = mk(mwid_pkg::K_ALU, mwid_pkg::F_SUB, rag, rag, mwid_pkg::NOREG,
                                  mwid_pkg::STACK_STEP, 1'b0, mwid_pkg::UNCOND);
                        dec1 = mk(mwid_pkg::K_ST, mwid_pkg::F_ADD, mwid_pkg::NOREG, rag, rdh,
                                  32'd0, 1'b0, mwid_pkg::UNCOND);
                        dec_two = 1'b1;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                mwid_pkg::OP16_SWFP:
                begin
                    ok   = (c16[2:0] == mwid_pkg::F3_SWFP);
                    dec0 = mk(mwid_pkg::K_ST, mwid_pkg::F_ADD, mwid_pkg::NOREG,
                              mwid_pkg::FP_REG, r8, {25'd0, c16[7:3], 2'b00}, 1'b0,
                              mwid_pkg::UNCOND);
                end
                default: ok = 1'b0;
            endcase
        end
        else
        begin
            // parallel-execution word
            ok     = 1'b0;
            len    = mwid_pkg::LEN32;
            err_st = mwid_pkg::ST_PARALLEL;
        end

        if (!ok)
        begin
            dec0        = err;
            dec0.status = err_st;
            dec_two     = 1'b0;
        end
        dec0.instr_length = len;
        dec1.instr_length = len;
        dec0.last_op      = !dec_two;
        dec1.last_op      = 1'b1;
    end

    // ------------------------------------------------------------------
    // Output register and second micro-op holding register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (advance)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_next        = dec0;
                out_valid_next  = accept;
                pend_next       = dec1;
                pend_valid_next = accept && dec_two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// ===== dv/mwid_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// mwid_tb_pkg
// Micro-op predictor and scoreboard for the mixed-width decoder bench.
// ----------------------------------------------------------------------------
`default_nettype none

package mwid_tb_pkg;

    typedef mwid_pkg::uop_t uop_q_t[$];

    localparam logic [3:0] NO_FUNC    = 4'd0;
    localparam logic [1:0] AL_ALIGNED = 2'd0;
    localparam logic [1:0] AL_ODD_LO  = 2'd1;
    localparam logic [1:0] AL_UPPER   = 2'd2;
    localparam logic [1:0] AL_ODD_HI  = 2'd3;

    function automatic mwid_pkg::uop_t plain_uop(logic [2:0] kind, logic [3:0] func,
                                                 logic [5:0] dst, logic [5:0] sa,
                                                 logic [5:0] sb, logic [31:0] imm,
                                                 logic flags, logic [5:0] cond);
        mwid_pkg::uop_t u;
        u.status       = mwid_pkg::ST_OK;
        u.op_kind      = kind;
        u.alu_func     = func;
        u.dest_reg     = dst;
        u.src_a_reg    = sa;
        u.src_b_reg    = sb;
        u.immediate    = imm;
        u.set_flags    = flags;
        u.condition    = cond;
        u.instr_length = mwid_pkg::LEN16;
        u.last_op      = 1'b1;
        return u;
    endfunction

    function automatic mwid_pkg::uop_t alu_uop(logic [3:0] func, logic [5:0] dst,
                                               logic [5:0] sa, logic [5:0] sb,
                                               logic [31:0] imm, logic flags);
        return plain_uop(mwid_pkg::K_ALU, func, dst, sa, sb, imm, flags, mwid_pkg::UNCOND);
    endfunction

    function automatic mwid_pkg::uop_t fault_uop(logic [1:0] st, logic [2:0] len);
        mwid_pkg::uop_t u;
        u = plain_uop(mwid_pkg::K_NOP, NO_FUNC, mwid_pkg::NOREG, mwid_pkg::NOREG,
                      mwid_pkg::NOREG, 32'd0, 1'b0, mwid_pkg::UNCOND);
        u.status       = st;
        u.instr_length = len;
        return u;
    endfunction

    // 30-bit code with parity bits removed; empty queue = unsupported
    function automatic uop_q_t decode32(logic [29:0] c);
        uop_q_t      q;
        logic [4:0]  op;
        logic [5:0]  rd;
        logic [5:0]  ra;
        logic [5:0]  rb;
        logic        cu;
        logic [15:0] imm16;
        logic [2:0]  f3;
        op    = c[29:25];
        rd    = {1'b0, c[24:20]};
        ra    = {1'b0, c[19:15]};
        rb    = {1'b0, c[14:10]};
        cu    = c[0];
        imm16 = c[16:1];
        f3    = c[19:17];
        if (op == mwid_pkg::OP32_SPECIAL)
        begin
            case (c[6:1])
                mwid_pkg::FN_NOP:
                    q = {q, plain_uop(mwid_pkg::K_NOP, NO_FUNC, mwid_pkg::NOREG, mwid_pkg::NOREG,
                                      mwid_pkg::NOREG, 32'd0, 1'b0, mwid_pkg::UNCOND)};
                mwid_pkg::FN_ADD:  q = {q, alu_uop(mwid_pkg::F_ADD, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_ADDC: q = {q, alu_uop(mwid_pkg::F_ADDC, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_SUB:  q = {q, alu_uop(mwid_pkg::F_SUB, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_SUBC: q = {q, alu_uop(mwid_pkg::F_SUBC, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_CMP:
                    if (rd[1:0] == 2'b11)
                        q = {q, alu_uop(mwid_pkg::F_SUB, mwid_pkg::NOREG, ra, rb, 32'd0, 1'b1)};
                mwid_pkg::FN_CMPZ:
                    if (rd[1:0] == 2'b11)
                        q = {q, alu_uop(mwid_pkg::F_SUB, mwid_pkg::NOREG, ra, mwid_pkg::NOREG,
                                        32'd0, 1'b1)};
                mwid_pkg::FN_NEG:
                    q = {q, alu_uop(mwid_pkg::F_SUB, rd, mwid_pkg::NOREG, rb, 32'd0, cu)};
                mwid_pkg::FN_AND:  q = {q, alu_uop(mwid_pkg::F_AND, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_OR:   q = {q, alu_uop(mwid_pkg::F_OR, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_NOT:
                    q = {q, alu_uop(mwid_pkg::F_XOR, rd, ra, mwid_pkg::NOREG, 32'hFFFF_FFFF,
                                    cu)};
                mwid_pkg::FN_XOR:  q = {q, alu_uop(mwid_pkg::F_XOR, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_BITCLR:
                    q = {q, alu_uop(mwid_pkg::F_AND, rd, ra, mwid_pkg::NOREG,
                                    ~(32'd1 << rb[4:0]), cu)};
                mwid_pkg::FN_BITSET:
                    q = {q, alu_uop(mwid_pkg::F_OR, rd, ra, mwid_pkg::NOREG,
                                    32'd1 << rb[4:0], cu)};
                mwid_pkg::FN_BITTST:
                    q = {q, alu_uop(mwid_pkg::F_AND, mwid_pkg::NOREG, ra, mwid_pkg::NOREG,
                                    32'd1 << rb[4:0], cu)};
                mwid_pkg::FN_BITTGL:
                    q = {q, alu_uop(mwid_pkg::F_XOR, mwid_pkg::NOREG, ra, mwid_pkg::NOREG,
                                    32'd1 << rb[4:0], cu)};
                mwid_pkg::FN_SLL:  q = {q, alu_uop(mwid_pkg::F_SLL, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_SRL:  q = {q, alu_uop(mwid_pkg::F_SRL, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_SRA:  q = {q, alu_uop(mwid_pkg::F_SRA, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_ROR:  q = {q, alu_uop(mwid_pkg::F_ROR, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_ROL:  q = {q, alu_uop(mwid_pkg::F_ROL, rd, ra, rb, 32'd0, cu)};
                mwid_pkg::FN_MV:
                    q = {q, plain_uop(mwid_pkg::K_MOV, NO_FUNC, rd, ra, mwid_pkg::NOREG, 32'd0,
                                      1'b0, rb)};
                default:   ;
            endcase
        end
        else if (op == mwid_pkg::OP32_IMM && f3 == mwid_pkg::F3_LDI)
            q = {q, plain_uop(mwid_pkg::K_MOV, NO_FUNC, rd, mwid_pkg::NOREG, mwid_pkg::NOREG,
                              {{16{imm16[15]}}, imm16}, 1'b0, mwid_pkg::UNCOND)};
        else if (op == mwid_pkg::OP32_IMMHI && f3 == mwid_pkg::F3_LDI)
            q = {q, plain_uop(mwid_pkg::K_MOV, NO_FUNC, rd, mwid_pkg::NOREG, mwid_pkg::NOREG,
                              {imm16, 16'h0000}, 1'b0, mwid_pkg::UNCOND)};
        return q;
    endfunction

    // 15-bit halfword code; empty queue = unsupported
    function automatic uop_q_t decode16(logic [14:0] c);
        uop_q_t     q;
        logic [5:0] r8;
        logic [5:0] rdh;
        logic [5:0] rag;
        r8  = {2'b00, c[11:8]};
        rdh = {1'b0, c[7], c[11:8]};
        rag = {3'b000, c[6:4]};
        if (c[14:12] == mwid_pkg::OP16_MISC)
        begin
            if (c[3:0] == mwid_pkg::F4_MV)
                q = {q, plain_uop(mwid_pkg::K_MOV, NO_FUNC, r8, {2'b00, c[7:4]},
                                  mwid_pkg::NOREG, 32'd0, 1'b0, mwid_pkg::UNCOND)};
        end
        else if (c[14:12] == mwid_pkg::OP16_STACK)
        begin
            if (c[3:0] == mwid_pkg::F4_POP)
            begin
                q = {q, plain_uop(mwid_pkg::K_LD, NO_FUNC, rdh, rag, mwid_pkg::NOREG, 32'd0,
                                  1'b0, mwid_pkg::UNCOND)};
                q = {q, alu_uop(mwid_pkg::F_ADD, rag, rag, mwid_pkg::NOREG,
                                mwid_pkg::STACK_STEP, 1'b0)};
            end
            else if (c[3:0] == mwid_pkg::F4_PUSH)
            begin
                q = {q, alu_uop(mwid_pkg::F_SUB, rag, rag, mwid_pkg::NOREG,
                                mwid_pkg::STACK_STEP, 1'b0)};
                q = {q, plain_uop(mwid_pkg::K_ST, NO_FUNC, mwid_pkg::NOREG, rag, rdh, 32'd0,
                                  1'b0, mwid_pkg::UNCOND)};
            end
        end
        else if (c[14:12] == mwid_pkg::OP16_SWFP && c[2:0] == mwid_pkg::F3_SWFP)
            q = {q, plain_uop(mwid_pkg::K_ST, NO_FUNC, mwid_pkg::NOREG, mwid_pkg::FP_REG, r8,
                              {25'd0, c[7:3], 2'b00}, 1'b0, mwid_pkg::UNCOND)};
        return q;
    endfunction

    function automatic uop_q_t predict_uops(mwid_pkg::fetch_t f);
        uop_q_t         q;
        logic [31:0]    w;
        logic [2:0]     len;
        mwid_pkg::uop_t u;
        w = f.fetch_word;
        if (f.address_low == AL_UPPER)
            w = w >> 16;
        if (f.address_low == AL_ALIGNED && w[31] && w[15])
        begin
            len = mwid_pkg::LEN32;
            q   = decode32({w[30:16], w[14:0]});
            if (q.size() == 0)
                q = {q, fault_uop(mwid_pkg::ST_BAD32, mwid_pkg::LEN32)};
        end
        else if (f.address_low == AL_ALIGNED && w[15])
        begin
            len = mwid_pkg::LEN32;
            q   = {q, fault_uop(mwid_pkg::ST_PARALLEL, mwid_pkg::LEN32)};
        end
        else
        begin
            len = mwid_pkg::LEN16;
            q   = decode16(w[14:0]);
            if (q.size() == 0)
                q = {q, fault_uop(mwid_pkg::ST_BAD16, mwid_pkg::LEN16)};
        end
        for (int i = 0; i < q.size(); i++)
        begin
            u              = q[i];
            u.instr_length = len;
            u.last_op      = (i == q.size() - 1);
            q[i]           = u;
        end
        return q;
    endfunction

    class decode_scoreboard;
        mwid_pkg::uop_t pending_uops[$];
        int unsigned    fetch_count    = 0;
        int unsigned    uop_count      = 0;
        int unsigned    pair_count     = 0;
        int unsigned    fault_count    = 0;
        int unsigned    mismatch_count = 0;

        function void note_fetch(mwid_pkg::fetch_t f);
            uop_q_t q;
            q = predict_uops(f);
            fetch_count++;
            if (q.size() == 2)
                pair_count++;
            if (q[0].status != mwid_pkg::ST_OK)
                fault_count++;
            foreach (q[i])
                pending_uops = {pending_uops, q[i]};
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_uop(mwid_pkg::uop_t got);
            mwid_pkg::uop_t want;
            uop_count++;
            if (pending_uops.size() == 0)
            begin
                $error("micro-op with nothing pending: %h", got);
                mismatch_count++;
                return;
            end
            want = pending_uops.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("op_kind", 32'(want.op_kind), 32'(got.op_kind));
            check_field("alu_func", 32'(want.alu_func), 32'(got.alu_func));
            check_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
            check_field("src_a_reg", 32'(want.src_a_reg), 32'(got.src_a_reg));
            check_field("src_b_reg", 32'(want.src_b_reg), 32'(got.src_b_reg));
            check_field("immediate", want.immediate, got.immediate);
            check_field("set_flags", 32'(want.set_flags), 32'(got.set_flags));
            check_field("condition", 32'(want.condition), 32'(got.condition));
            check_field("instr_length", 32'(want.instr_length), 32'(got.instr_length));
            check_field("last_op", 32'(want.last_op), 32'(got.last_op));
        endfunction

        function int unsigned backlog();
            return pending_uops.size();
        endfunction
    endclass

endpackage

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Bench for the mixed-width instruction decoder: directed encodings of every
// operation and error path, then mostly well-formed random instructions with
// random handshake gaps on both channels, checked against a predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int RANDOM_ITEMS = 1850;
    localparam int FN_COUNT     = 22;

    // Not a sub-function of the special major opcode
    localparam logic [5:0] FN_UNUSED = 6'h3F;

    // Every sub-function of the 32-bit special major opcode
    localparam logic [5:0] FN_LIST [FN_COUNT] = '{
        mwid_pkg::FN_NOP, mwid_pkg::FN_ADD, mwid_pkg::FN_ADDC, mwid_pkg::FN_SUB,
        mwid_pkg::FN_SUBC, mwid_pkg::FN_CMP, mwid_pkg::FN_CMPZ, mwid_pkg::FN_NEG,
        mwid_pkg::FN_AND, mwid_pkg::FN_OR, mwid_pkg::FN_NOT, mwid_pkg::FN_XOR,
        mwid_pkg::FN_BITCLR, mwid_pkg::FN_BITSET, mwid_pkg::FN_BITTST, mwid_pkg::FN_BITTGL,
        mwid_pkg::FN_SLL, mwid_pkg::FN_SRL, mwid_pkg::FN_SRA, mwid_pkg::FN_ROR,
        mwid_pkg::FN_ROL, mwid_pkg::FN_MV
    };

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             fetch_valid = 1'b0;
    logic             fetch_ready;
    mwid_pkg::fetch_t fetch       = '0;
    logic             uop_valid;
    logic             uop_ready   = 1'b0;
    mwid_pkg::uop_t   uop;

    mwid_tb_pkg::decode_scoreboard sb;

    // Random idling on both channels; cleared for the tail of the run
    bit          idle_enable = 1'b1;
    int unsigned ready_left  = 0;

    mixed_width_instruction_decoder_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .fetch_valid (fetch_valid),
        .fetch_ready (fetch_ready),
        .fetch       (fetch),
        .uop_valid   (uop_valid),
        .uop_ready   (uop_ready),
        .uop         (uop)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Encoding helpers
    // ------------------------------------------------------------------

    function automatic mwid_pkg::fetch_t mk_fetch(logic [1:0] al, logic [31:0] w);
        mwid_pkg::fetch_t f;
        f.address_low = al;
        f.fetch_word  = w;
        return f;
    endfunction

    // Re-insert the two parity bits around a 30-bit code
    function automatic logic [31:0] word32(logic [29:0] c);
        return {1'b1, c[29:15], 1'b1, c[14:0]};
    endfunction

    function automatic logic [29:0] special_code(logic [5:0] fn, logic [4:0] rd, logic [4:0] ra,
                                                 logic [4:0] rb, logic [2:0] pad, logic cu);
        return {mwid_pkg::OP32_SPECIAL, rd, ra, rb, pad, fn, cu};
    endfunction

    // ldi / ldis: sub-function sits in the top of the ra field
    function automatic logic [29:0] imm_code(logic [4:0] op, logic [4:0] rd, logic [15:0] imm,
                                             logic cu);
        return {op, rd, mwid_pkg::F3_LDI, imm, cu};
    endfunction

    function automatic logic [14:0] mv16(logic [3:0] rd, logic [3:0] rs);
        return {mwid_pkg::OP16_MISC, rd, rs, mwid_pkg::F4_MV};
    endfunction

    // pop!/push!: rD high bit sits at bit 7, next to the 3-bit rA
    function automatic logic [14:0] stack16(logic [3:0] f4, logic [4:0] rd, logic [2:0] ra);
        return {mwid_pkg::OP16_STACK, rd[3:0], rd[4], ra, f4};
    endfunction

    function automatic logic [14:0] swfp16(logic [3:0] rd, logic [4:0] imm5);
        return {mwid_pkg::OP16_SWFP, rd, imm5, mwid_pkg::F3_SWFP};
    endfunction

    // Put a halfword where the given address offset reads it; every other
    // bit random, except that an aligned 16-bit instruction has bit 15 clear
    function automatic mwid_pkg::fetch_t place16(logic [14:0] h, logic [1:0] al);
        logic [31:0] w;
        w = $urandom();
        if (al == mwid_tb_pkg::AL_UPPER)
            w[30:16] = h;
        else
        begin
            w[14:0] = h;
            if (al == mwid_tb_pkg::AL_ALIGNED)
                w[15] = 1'b0;
        end
        return mk_fetch(al, w);
    endfunction

    // Mostly well-formed instructions with random fields, the rest noise
    function automatic mwid_pkg::fetch_t random_fetch();
        int unsigned sel;
        logic [31:0] w;
        logic [4:0]  rd;
        logic [4:0]  fi;
        logic [14:0] h;
        sel = $urandom_range(0, 99);
        w   = $urandom();
        rd  = 5'($urandom_range(0, 31));
        fi  = 5'($urandom_range(0, FN_COUNT - 1));
        if ($urandom_range(0, 1) == 1)
            rd[1:0] = 2'b11;  // lets cmp/cmpz decode about half the time
        if (sel < 35)
            return mk_fetch(mwid_tb_pkg::AL_ALIGNED,
                            word32(special_code(FN_LIST[fi], rd, w[4:0], w[9:5], w[12:10],
                                                w[13])));
        if (sel < 45)
            return mk_fetch(mwid_tb_pkg::AL_ALIGNED,
                            word32(imm_code(sel[0] ? mwid_pkg::OP32_IMM : mwid_pkg::OP32_IMMHI,
                                            rd, w[15:0], w[16])));
        if (sel < 70)
        begin
            case ($urandom_range(0, 3))
                0:       h = mv16(w[3:0], w[7:4]);
                1:       h = stack16(mwid_pkg::F4_POP, rd, w[2:0]);
                2:       h = stack16(mwid_pkg::F4_PUSH, rd, w[2:0]);
                default: h = swfp16(w[3:0], w[8:4]);
            endcase
            return place16(h, 2'($urandom_range(0, 3)));
        end
        if (sel < 78)  // any 32-bit code
            return mk_fetch(mwid_tb_pkg::AL_ALIGNED, w | 32'h8000_8000);
        if (sel < 85)  // parallel word
            return mk_fetch(mwid_tb_pkg::AL_ALIGNED, (w | 32'h0000_8000) & 32'h7FFF_FFFF);
        return mk_fetch(2'($urandom_range(0, 3)), w);
    endfunction

    // ------------------------------------------------------------------
    // Fetch side driver
    // ------------------------------------------------------------------

    // One fetch transfer, optionally after an idle burst. Valid is only
    // dropped when a gap is taken, so back-to-back items keep it high.
    task automatic send_fetch(mwid_pkg::fetch_t f);
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            fetch_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        fetch_valid <= 1'b1;
        fetch       <= f;
        do
            @(posedge clk);
        while (!fetch_ready);
        sb.note_fetch(f);
    endtask

    // Sender holds off until every predicted micro-op has been seen
    task automatic hold_until_drained();
        fetch_valid <= 1'b0;
        while (sb.backlog() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        logic       ext;
        logic [4:0] rx;
        // every 32-bit special op, alternating all-ones and all-zero fields (rD is 3 when zero)
        for (int i = 0; i < FN_COUNT; i++)
        begin
            ext = i[0];
            rx  = ext ? 5'd31 : 5'd0;
            send_fetch(mk_fetch(mwid_tb_pkg::AL_ALIGNED,
                                word32(special_code(FN_LIST[5'(i)], ext ? 5'd31 : 5'd3,
                                                    rx, rx, {3{ext}}, ext))));
        end
        // cmp and cmpz with rD low bits not both set are rejected
        send_fetch(mk_fetch(mwid_tb_pkg::AL_ALIGNED,
                            word32(special_code(mwid_pkg::FN_CMP, 5'd4, 5'd1, 5'd2, 3'd0,
                                                1'b1))));
        send_fetch(mk_fetch(mwid_tb_pkg::AL_ALIGNED,
                            word32(special_code(mwid_pkg::FN_CMPZ, 5'd30, 5'd1, 5'd2, 3'd0,
                                                1'b0))));
        // ldi sign extension both ways, ldis with all-ones immediate
        send_fetch(mk_fetch(mwid_tb_pkg::AL_ALIGNED,
                            word32(imm_code(mwid_pkg::OP32_IMM, 5'd31, 16'h8000, 1'b1))));
        send_fetch(mk_fetch(mwid_tb_pkg::AL_ALIGNED,
                            word32(imm_code(mwid_pkg::OP32_IMM, 5'd0, 16'h7FFF, 1'b0))));
        send_fetch(mk_fetch(mwid_tb_pkg::AL_ALIGNED,
                            word32(imm_code(mwid_pkg::OP32_IMMHI, 5'd0, 16'hFFFF, 1'b1))));
        // unsupported 32-bit, parallel word, all-ones word
        send_fetch(mk_fetch(mwid_tb_pkg::AL_ALIGNED,
                            word32(special_code(FN_UNUSED, 5'd1, 5'd1, 5'd1, 3'd0, 1'b0))));
        send_fetch(mk_fetch(mwid_tb_pkg::AL_ALIGNED, 32'h7FFF_FFFF));
        send_fetch(mk_fetch(mwid_tb_pkg::AL_ALIGNED, 32'hFFFF_FFFF));
        // 16-bit forms at each address offset, odd ones included
        send_fetch(place16(mv16(4'd15, 4'd0), mwid_tb_pkg::AL_ALIGNED));
        send_fetch(place16(stack16(mwid_pkg::F4_POP, 5'd31, 3'd7), mwid_tb_pkg::AL_UPPER));
        send_fetch(place16(stack16(mwid_pkg::F4_PUSH, 5'd0, 3'd0), mwid_tb_pkg::AL_ODD_LO));
        send_fetch(place16(swfp16(4'd15, 5'd31), mwid_tb_pkg::AL_ODD_HI));
        // unsupported 16-bit
        send_fetch(mk_fetch(mwid_tb_pkg::AL_ALIGNED, 32'h0000_7FFF));
        // odd address, bit 15 clear
        send_fetch(mk_fetch(mwid_tb_pkg::AL_ODD_HI, 32'h0000_0000));
    endtask

    // ------------------------------------------------------------------
    // Result side: ready bursts and monitor
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            if (idle_enable && $urandom_range(0, 2) == 0)
            begin
                uop_ready  <= 1'b0;
                ready_left = $urandom_range(1, 10) - 1;
            end
            else
            begin
                uop_ready  <= 1'b1;
                ready_left = $urandom_range(1, 20) - 1;
            end
        end
        else
            ready_left = ready_left - 1;
    end

    // Values read here are the ones the edge itself saw
    always @(posedge clk)
    begin
        if (rst_n && uop_valid && uop_ready)
            sb.check_uop(uop);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        hold_until_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                hold_until_drained();
            if (i == RANDOM_ITEMS - 300)
                idle_enable = 1'b0;  // tail runs at full rate
            send_fetch(random_fetch());
        end
        fetch_valid <= 1'b0;

        while (sb.backlog() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);  // catch any stray micro-op

        $display("Covered %0d fetch transfers and %0d micro-ops,", sb.fetch_count, sb.uop_count);
        $display("with %0d pop/push pairs and %0d errors", sb.pair_count, sb.fault_count);
        if (sb.mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial
    begin
        #5000000;
        $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire
